[sv/lcdnw_pkg.sv]
package lcdnw_pkg;

   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_COMMAND = 3'd1;
   localparam logic [2:0] OP_CHAR    = 3'd2;
   localparam logic [2:0] OP_GOTO    = 3'd3;
   localparam logic [2:0] OP_NUMBER  = 3'd4;

   localparam int STEP_W = 4;
   localparam int DIGITS = 5;
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

   localparam logic [STEP_W-1:0] ENTRY_INIT    = 4'd0;
   localparam logic [STEP_W-1:0] ENTRY_COMMAND = 4'd7;
   localparam logic [STEP_W-1:0] ENTRY_CHAR    = 4'd9;
   localparam logic [STEP_W-1:0] ENTRY_NUMBER  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_POP      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_NONE     = 4'd0;

   localparam logic [3:0]  ASCII_DIGIT_HIGH = 4'h3;
   localparam logic [1:0]  GOTO_ADDR_SET    = 2'b10;
   localparam logic [31:0] DIV10_RECIP      = 32'd52429;
   localparam int          DIV10_SHIFT      = 19;

   typedef enum logic [1:0] {
      SRC_CONST = 2'd0,
      SRC_HIGH  = 2'd1,
      SRC_LOW   = 2'd2
   } nib_src_type;

   typedef enum logic [1:0] {
      LAST_NO        = 2'd0,
      LAST_YES       = 2'd1,
      LAST_IF_UNCONF = 2'd2,
      LAST_IF_EMPTY  = 2'd3
   } last_sel_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_DIVIDE  = 2'd1,
      ACT_POP     = 2'd2,
      ACT_SET_CFG = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT          = 3'd0,
      COND_END           = 3'd1,
      COND_END_IF_UNCONF = 3'd2,
      COND_LOOP_IF_QUOT  = 3'd3,
      COND_LOOP_IF_DIGIT = 3'd4
   } cond_type;

   typedef struct packed {
      logic              emit;
      nib_src_type       src;
      logic [3:0]        const_nib;
      logic              rs;
      last_sel_type      last_sel;
      act_type           act;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic configured;
      logic quot_nz;
      logic digits_nz;
   } status_type;

   function automatic ucode_type mk(input logic emit, input nib_src_type src,
                                    input logic [3:0] const_nib, input logic rs,
                                    input last_sel_type last_sel, input act_type act,
                                    input cond_type cond, input logic [STEP_W-1:0] target);
      ucode_type w;
      w.emit      = emit;
      w.src       = src;
      w.const_nib = const_nib;
      w.rs        = rs;
      w.last_sel  = last_sel;
      w.act       = act;
      w.cond      = cond;
      w.target    = target;
      return w;
   endfunction

   // Microprogram: init, command/goto, character, then the decimal number loops.
   function automatic ucode_type ucode(input logic [STEP_W-1:0] addr);
      ucode_type w;
      case (addr)
         4'd0:    w = mk(1'b1, SRC_CONST, 4'h2, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd1:    w = mk(1'b1, SRC_CONST, 4'h2, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd2:    w = mk(1'b1, SRC_CONST, 4'h8, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd3:    w = mk(1'b1, SRC_CONST, 4'h0, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd4:    w = mk(1'b1, SRC_CONST, 4'hC, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd5:    w = mk(1'b1, SRC_CONST, 4'h0, 1'b0, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd6:    w = mk(1'b1, SRC_CONST, 4'h1, 1'b0, LAST_YES, ACT_SET_CFG, COND_END,
                         STEP_NONE);
         4'd7:    w = mk(1'b1, SRC_HIGH, 4'h0, 1'b0, LAST_IF_UNCONF, ACT_NONE,
                         COND_END_IF_UNCONF, STEP_NONE);
         4'd8:    w = mk(1'b1, SRC_LOW, 4'h0, 1'b0, LAST_YES, ACT_NONE, COND_END, STEP_NONE);
         4'd9:    w = mk(1'b1, SRC_HIGH, 4'h0, 1'b1, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd10:   w = mk(1'b1, SRC_LOW, 4'h0, 1'b1, LAST_YES, ACT_NONE, COND_END, STEP_NONE);
         4'd11:   w = mk(1'b0, SRC_CONST, 4'h0, 1'b0, LAST_NO, ACT_DIVIDE, COND_LOOP_IF_QUOT,
                         ENTRY_NUMBER);
         4'd12:   w = mk(1'b0, SRC_CONST, 4'h0, 1'b0, LAST_NO, ACT_POP, COND_NEXT, STEP_NONE);
         4'd13:   w = mk(1'b1, SRC_HIGH, 4'h0, 1'b1, LAST_NO, ACT_NONE, COND_NEXT, STEP_NONE);
         4'd14:   w = mk(1'b1, SRC_LOW, 4'h0, 1'b1, LAST_IF_EMPTY, ACT_NONE,
                         COND_LOOP_IF_DIGIT, STEP_POP);
         default: w = mk(1'b0, SRC_CONST, 4'h0, 1'b0, LAST_NO, ACT_NONE, COND_END, STEP_NONE);
      endcase
      return w;
   endfunction

endpackage

[sv/lcdnw_div10.sv]
module lcdnw_div10 (
   input  logic [15:0] value,
   output logic [15:0] quotient,
   output logic [3:0]  remainder
);

   logic [31:0] product;
   logic [15:0] times_ten;
   logic [15:0] diff;

   assign product   = 32'(value) * lcdnw_pkg::DIV10_RECIP;
   assign quotient  = 16'(product >> lcdnw_pkg::DIV10_SHIFT);
   assign times_ten = {quotient[12:0], 3'b000} + {quotient[14:0], 1'b0};
   assign diff      = value - times_ten;
   assign remainder = diff[3:0];

endmodule

[sv/lcdnw_sequencer.sv]
module lcdnw_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lcdnw_pkg::STEP_W-1:0]     entry,
   input  logic                             advance,
   input  lcdnw_pkg::status_type            status,
   output logic                             busy,
   output lcdnw_pkg::ucode_type             ctrl
);

   logic [lcdnw_pkg::STEP_W-1:0] step_ff;
   logic [lcdnw_pkg::STEP_W-1:0] step_in;
   logic                         busy_ff;
   logic                         busy_in;
   logic [lcdnw_pkg::STEP_W-1:0] step_next;

   assign ctrl      = lcdnw_pkg::ucode(step_ff);
   assign busy      = busy_ff;
   assign step_next = step_ff + 1'b1;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = entry;
         busy_in = 1'b1;
      end else if (advance) begin
         case (ctrl.cond)
            lcdnw_pkg::COND_NEXT: begin
               step_in = step_next;
            end
            lcdnw_pkg::COND_END: begin
               busy_in = 1'b0;
            end
            lcdnw_pkg::COND_END_IF_UNCONF: begin
               if (status.configured) step_in = step_next;
               else busy_in = 1'b0;
            end
            lcdnw_pkg::COND_LOOP_IF_QUOT: begin
               step_in = status.quot_nz ? ctrl.target : step_next;
            end
            lcdnw_pkg::COND_LOOP_IF_DIGIT: begin
               if (status.digits_nz) step_in = ctrl.target;
               else busy_in = 1'b0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

[sv/char_lcd_nibble_write_sequencer.sv]
// Channel  Direction  Ports                                            Handshake
// req      in         req_opcode, req_byte_value, req_row, req_col,    req_valid/req_ready
//                     req_number
// rsp      out        rsp_reg_select, rsp_nibble, rsp_last             rsp_valid/rsp_ready
//
// One word is taken at a time; req_ready is high whenever no microprogram is running.
// The microprogram emits at most one nibble word per cycle into the output register.
// Init sends a fixed nibble sequence; a command or goto sends its high nibble and, once
// configured, its low one; a character sends both nibbles; a number runs one divide step
// per digit, then per digit one pop step and two nibbles.
// Reset clears the configured flag and the sequencer; a stalled output freezes the step.
module char_lcd_nibble_write_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_byte_value,
   input  logic        req_row,
   input  logic [5:0]  req_col,
   input  logic [15:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_last
);

   localparam int CW = lcdnw_pkg::DIGIT_CNT_W;
   localparam int ND = lcdnw_pkg::DIGITS;

   lcdnw_pkg::ucode_type         ctrl;
   lcdnw_pkg::status_type        status;
   logic                         busy;
   logic                         start;
   logic                         start_ok;
   logic                         advance;
   logic [lcdnw_pkg::STEP_W-1:0] entry;
   logic [7:0]                   load_byte;

   logic                         configured_ff;
   logic [7:0]                   byte_ff;
   logic [15:0]                  value_ff;
   logic [CW-1:0]                ndig_ff;
   logic [3:0]                   digit_ff [ND];
   logic                         rsp_valid_ff;
   logic                         rsp_rs_ff;
   logic [3:0]                   rsp_nibble_ff;
   logic                         rsp_last_ff;

   logic [15:0]                  quotient;
   logic [3:0]                   remainder;
   logic [3:0]                   nib_sel;
   logic                         last_sel;

   lcdnw_div10 u_div10 (
      .value     (value_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   lcdnw_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .entry   (entry),
      .advance (advance),
      .status  (status),
      .busy    (busy),
      .ctrl    (ctrl)
   );

   assign status.configured = configured_ff;
   assign status.quot_nz    = (quotient != 16'd0);
   assign status.digits_nz  = (ndig_ff != '0);

   assign req_ready = !busy;
   assign start     = req_valid && req_ready && start_ok;
   assign advance   = busy && (!ctrl.emit || !rsp_valid_ff || rsp_ready);

   always_comb begin
      entry     = lcdnw_pkg::ENTRY_INIT;
      start_ok  = 1'b1;
      load_byte = req_byte_value;
      case (req_opcode)
         lcdnw_pkg::OP_INIT:    entry = lcdnw_pkg::ENTRY_INIT;
         lcdnw_pkg::OP_COMMAND: entry = lcdnw_pkg::ENTRY_COMMAND;
         lcdnw_pkg::OP_CHAR:    entry = lcdnw_pkg::ENTRY_CHAR;
         lcdnw_pkg::OP_GOTO: begin
            entry     = lcdnw_pkg::ENTRY_COMMAND;
            load_byte = {1'b1, req_row, req_col} | {lcdnw_pkg::GOTO_ADDR_SET, 6'd0};
         end
         lcdnw_pkg::OP_NUMBER:  entry = lcdnw_pkg::ENTRY_NUMBER;
         default:               start_ok = 1'b0;
      endcase
   end

   always_comb begin
      case (ctrl.src)
         lcdnw_pkg::SRC_CONST: nib_sel = ctrl.const_nib;
         lcdnw_pkg::SRC_HIGH:  nib_sel = byte_ff[7:4];
         lcdnw_pkg::SRC_LOW:   nib_sel = byte_ff[3:0];
         default:              nib_sel = ctrl.const_nib;
      endcase
      case (ctrl.last_sel)
         lcdnw_pkg::LAST_YES:       last_sel = 1'b1;
         lcdnw_pkg::LAST_IF_UNCONF: last_sel = !configured_ff;
         lcdnw_pkg::LAST_IF_EMPTY:  last_sel = (ndig_ff == '0);
         default:                   last_sel = 1'b0;
      endcase
   end

   // Digits form a small stack: divide steps push the low digit, pops read the newest.
   always_ff @(posedge clock) begin
      if (reset) begin
         configured_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ndig_ff       <= '0;
      end else begin
         if (start) begin
            byte_ff  <= load_byte;
            value_ff <= req_number;
            ndig_ff  <= '0;
         end else if (advance) begin
            case (ctrl.act)
               lcdnw_pkg::ACT_DIVIDE: begin
                  value_ff    <= quotient;
                  ndig_ff     <= ndig_ff + 1'b1;
                  digit_ff[0] <= remainder;
                  for (int i = 1; i < ND; i++) digit_ff[i] <= digit_ff[i-1];
               end
               lcdnw_pkg::ACT_POP: begin
                  byte_ff <= {lcdnw_pkg::ASCII_DIGIT_HIGH, digit_ff[0]};
                  ndig_ff <= ndig_ff - 1'b1;
                  for (int i = 0; i < ND - 1; i++) digit_ff[i] <= digit_ff[i+1];
               end
               lcdnw_pkg::ACT_SET_CFG: begin
                  configured_ff <= 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (advance && ctrl.emit) begin
            rsp_valid_ff  <= 1'b1;
            rsp_rs_ff     <= ctrl.rs;
            rsp_nibble_ff <= nib_sel;
            rsp_last_ff   <= last_sel;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_nibble     = rsp_nibble_ff;
   assign rsp_last       = rsp_last_ff;

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= CW'(ND))
      else $error("digit count exceeds stack depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (busy && ctrl.act == lcdnw_pkg::ACT_POP) |-> (ndig_ff != '0))
      else $error("digit pop from empty stack");

   a_cfg_sticky: assert property (@(posedge clock) disable iff (reset)
      configured_ff |=> configured_ff)
      else $error("configured flag cleared without reset");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> (ndig_ff == '0))
      else $error("digit stack not empty at program start");

endmodule
